// ----- hdl/bjd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bjd_pkg;

    typedef enum logic [1:0] {
        MODE_STATUS  = 2'd0,
        MODE_SUBMIT  = 2'd1,
        MODE_RECOVER = 2'd2
    } t_mode;

    localparam logic [1:0] CFG_OVF_EVEN = 2'd0;
    localparam logic [1:0] CFG_OVF_ODD  = 2'd1;
    localparam logic [1:0] CFG_MAX_REC  = 2'd2;

    localparam int FLAG_OOM    = 0;
    localparam int FLAG_SPILL  = 1;
    localparam int FLAG_FLUSH  = 2;
    localparam int FLAG_RENDER = 3;

    localparam logic [2:0] RECOVERY_SAT    = 3'd7;
    localparam logic [2:0] MAX_REC_DEFAULT = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic        has_bin;
        logic [31:0] render_list_start;
        logic [31:0] render_list_end;
        logic        int_out_of_memory;
        logic        int_spill;
        logic        int_bin_flushed;
        logic        int_render_done;
    } t_job_in;

    typedef struct packed {
        logic        accepted;
        logic [31:0] job_number;
        logic        bin_kick;
        logic        render_kick;
        logic [31:0] kick_render_start;
        logic [31:0] kick_render_end;
        logic        overflow_feed;
        logic [31:0] overflow_addr;
        logic [31:0] finished_number;
        logic        pipeline_idle;
        logic        slot_free;
        logic [3:0]  int_clear_mask;
    } t_job_out;

    typedef struct packed {
        logic [31:0] rl_start;
        logic [31:0] rl_end;
        logic [31:0] job;
    } t_qentry;

    // Scalar engine state that a service pass reads and updates.
    typedef struct packed {
        logic [31:0] bin_job;
        logic [31:0] bin_flushed_job;
        logic [31:0] finished_job;
        logic [31:0] render_job;
        logic        bin_busy;
        logic        render_busy;
        logic        bin_only_job;
        logic        oom_waiting;
        logic        oom_fed;
    } t_eng_state;

    // What one service pass did.
    typedef struct packed {
        logic [3:0]  clr;
        logic        feed;
        logic [31:0] feed_addr;
        logic        kick;
    } t_svc_act;

endpackage

`default_nettype wire

// ----- hdl/bjd_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bjd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/bjd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bjd_queue #(
    parameter int QUEUE_DEPTH = 4,
    parameter int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_wr_en,
    input  wire logic [HW-1:0]   i_wr_idx,
    input  wire bjd_pkg::t_qentry i_wr_data,
    input  wire logic [HW-1:0]   i_rd_idx,
    output bjd_pkg::t_qentry     o_rd_data
);
    import bjd_pkg::*;

    t_qentry r_mem [QUEUE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    // Only the queue head is ever read, so a plain mux does it.
    assign o_rd_data = r_mem[i_rd_idx];

endmodule

`default_nettype wire

// ----- hdl/bjd_svc.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bjd_svc #(
    parameter int QUEUE_DEPTH = 4,
    parameter int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    parameter int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire bjd_pkg::t_eng_state i_state,
    input  wire logic [3:0]          i_pend,
    input  wire logic [HW-1:0]       i_head,
    input  wire logic [CW-1:0]       i_count,
    input  wire bjd_pkg::t_qentry    i_entry,
    input  wire logic [31:0]         i_ovf_even,
    input  wire logic [31:0]         i_ovf_odd,
    output bjd_pkg::t_eng_state      o_state,
    output logic [3:0]               o_pend,
    output logic [HW-1:0]            o_head,
    output logic [CW-1:0]            o_count,
    output bjd_pkg::t_svc_act        o_act
);
    import bjd_pkg::*;

    always_comb begin
        logic [31:0] supply;
        o_state = i_state;
        o_pend  = i_pend;
        o_head  = i_head;
        o_count = i_count;
        o_act   = '0;

        if (o_pend[FLAG_OOM]) begin
            o_pend[FLAG_OOM]    = 1'b0;
            o_act.clr[FLAG_OOM] = 1'b1;
            o_state.oom_waiting = 1'b1;
        end
        if (o_pend[FLAG_SPILL]) begin
            o_pend[FLAG_SPILL]    = 1'b0;
            o_act.clr[FLAG_SPILL] = 1'b1;
        end

        // The refill goes to the supply of the job after the one binning.
        supply = o_state.bin_job[0] ? i_ovf_even : i_ovf_odd;
        if (o_state.oom_waiting && !o_state.render_busy) begin
            if (!o_state.oom_fed && supply != 32'd0) begin
                o_act.feed      = 1'b1;
                o_act.feed_addr = supply;
                o_state.oom_fed = 1'b1;
            end
            o_state.oom_waiting = 1'b0;
        end

        if (o_state.bin_busy && o_pend[FLAG_FLUSH]) begin
            o_pend[FLAG_FLUSH]      = 1'b0;
            o_act.clr[FLAG_FLUSH]   = 1'b1;
            o_state.bin_busy        = 1'b0;
            o_state.bin_flushed_job = o_state.bin_job;
            if (o_state.bin_only_job && o_state.finished_job < o_state.bin_job) begin
                o_state.finished_job = o_state.bin_job;
            end
        end

        if (o_state.render_busy && o_pend[FLAG_RENDER]) begin
            o_pend[FLAG_RENDER]    = 1'b0;
            o_act.clr[FLAG_RENDER] = 1'b1;
            o_state.render_busy    = 1'b0;
            o_state.finished_job   = o_state.render_job;
        end

        if (o_count != '0 && !o_state.render_busy
            && i_entry.job <= o_state.bin_flushed_job) begin
            o_state.render_job = i_entry.job;
            o_head = (o_head == HW'(QUEUE_DEPTH - 1)) ? '0 : o_head + HW'(1);
            o_count = o_count - CW'(1);
            o_pend[FLAG_RENDER]    = 1'b0;
            o_act.clr[FLAG_RENDER] = 1'b1;
            o_state.render_busy    = 1'b1;
            o_act.kick             = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/gpu_bin_render_job_dispatcher_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Payload   | Handshake
// i_job    | in        | t_job_in  | valid/ready, taken when both are high
// o_res    | out       | t_job_out | valid/ready, one result per event
// i_cfg_*  | in        | index/data| write when i_cfg_we is high, no stall
//
// An event lands in an input register; service logic (two
// service passes around the submit step) updates the engine state and
// fills the result register. One event per cycle is sustained while
// o_res.ready is high; the result is registered once the result register
// is free. When the result register is held by o_res.ready
// low, the input register still takes one more event before i_job.ready
// drops. Reset clears all control state and holds i_job.ready low; the
// render queue entries are not cleared, since only written entries are read.
module gpu_bin_render_job_dispatcher_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bjd_stream_if.sink       i_job,
    bjd_stream_if.source     o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    import bjd_pkg::*;

    localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [31:0]  r_ovf_even, r_ovf_odd;
    logic [2:0]   r_max_rec;

    logic         r_in_valid;
    t_job_in      r_in;
    logic         r_out_valid;
    t_job_out     r_out, n_out;

    t_eng_state   r_state, n_state;
    logic [31:0]  r_job_counter, n_job_counter;
    logic [HW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic         r_powered, n_powered;
    logic [2:0]   r_rec, n_rec;

    logic         adv;

    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_job.ready = i_rst_n && (!r_in_valid || adv);
    assign o_res.valid = r_out_valid;
    assign o_res.payload = r_out;

    // First service pass.
    t_eng_state    s1;
    logic [3:0]    p1;
    logic [HW-1:0] h1;
    logic [CW-1:0] c1;
    t_svc_act      a1;
    t_qentry       e0;

    bjd_svc #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_svc_first (
        .i_state   (r_state),
        .i_pend    ({r_in.int_render_done, r_in.int_bin_flushed,
                     r_in.int_spill, r_in.int_out_of_memory}),
        .i_head    (r_head),
        .i_count   (r_count),
        .i_entry   (e0),
        .i_ovf_even(r_ovf_even),
        .i_ovf_odd (r_ovf_odd),
        .o_state   (s1),
        .o_pend    (p1),
        .o_head    (h1),
        .o_count   (c1),
        .o_act     (a1)
    );

    // Submit step between the two passes.
    logic          take;
    logic [31:0]   seq;
    logic          has_list;
    t_eng_state    sm;
    logic [3:0]    pm;
    logic [CW-1:0] cm;
    logic [3:0]    clr_m;
    logic          feed_m;
    logic [31:0]   addr_m;
    logic [31:0]   bin_supply;
    logic [CW:0]   tail_sum;
    logic [HW-1:0] tail;
    t_qentry       wr_entry;
    t_qentry       e2;

    assign take     = (r_in.mode == MODE_SUBMIT) && r_powered && !s1.bin_busy
                      && (c1 < CW'(QUEUE_DEPTH));
    assign seq      = r_job_counter + 32'd1;
    assign has_list = r_in.render_list_start != r_in.render_list_end;
    assign bin_supply = seq[0] ? r_ovf_odd : r_ovf_even;
    assign tail_sum = {1'b0, c1} + (CW + 1)'(h1);
    assign tail     = (tail_sum >= (CW + 1)'(QUEUE_DEPTH))
                      ? HW'(tail_sum - (CW + 1)'(QUEUE_DEPTH)) : HW'(tail_sum);
    assign wr_entry = '{rl_start: r_in.render_list_start,
                        rl_end:   r_in.render_list_end,
                        job:      seq};
    // The second pass can only kick when the first did not, so the head is
    // unchanged; an empty queue means the head is the entry just written.
    assign e2 = (c1 == '0) ? wr_entry : e0;

    always_comb begin
        sm     = s1;
        pm     = p1;
        cm     = c1;
        clr_m  = '0;
        feed_m = 1'b0;
        addr_m = '0;
        if (has_list) begin
            cm = c1 + CW'(1);
            sm.bin_only_job = 1'b0;
            if (!r_in.has_bin) begin
                sm.bin_flushed_job = seq;
            end
        end else begin
            sm.bin_only_job = 1'b1;
            if (!r_in.has_bin) begin
                sm.finished_job = seq;
            end
        end
        if (r_in.has_bin) begin
            if (bin_supply != 32'd0) begin
                feed_m = 1'b1;
                addr_m = bin_supply;
            end
            pm[FLAG_FLUSH]    = 1'b0;
            clr_m[FLAG_FLUSH] = 1'b1;
            sm.bin_job     = seq;
            sm.bin_busy    = 1'b1;
            sm.oom_waiting = 1'b0;
            sm.oom_fed     = 1'b0;
        end
    end

    t_eng_state    s2;
    logic [3:0]    p2;
    logic [HW-1:0] h2;
    logic [CW-1:0] c2;
    t_svc_act      a2;

    bjd_svc #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_svc_second (
        .i_state   (sm),
        .i_pend    (pm),
        .i_head    (h1),
        .i_count   (cm),
        .i_entry   (e2),
        .i_ovf_even(r_ovf_even),
        .i_ovf_odd (r_ovf_odd),
        .o_state   (s2),
        .o_pend    (p2),
        .o_head    (h2),
        .o_count   (c2),
        .o_act     (a2)
    );

    bjd_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_wr_en  (adv && take && has_list),
        .i_wr_idx (tail),
        .i_wr_data(wr_entry),
        .i_rd_idx (r_head),
        .o_rd_data(e0)
    );

    always_comb begin
        n_state       = s1;
        n_head        = h1;
        n_count       = c1;
        n_job_counter = r_job_counter;
        n_powered     = r_powered;
        n_rec         = r_rec;
        n_out         = '0;
        n_out.render_kick   = a1.kick;
        n_out.kick_render_start = a1.kick ? e0.rl_start : 32'd0;
        n_out.kick_render_end   = a1.kick ? e0.rl_end : 32'd0;
        n_out.overflow_feed  = a1.feed;
        n_out.overflow_addr  = a1.feed_addr;
        n_out.int_clear_mask = a1.clr;

        unique case (r_in.mode)
            MODE_RECOVER: begin
                n_state = r_state;
                n_state.bin_busy        = 1'b0;
                n_state.render_busy     = 1'b0;
                n_state.bin_flushed_job = r_job_counter;
                n_state.finished_job    = r_job_counter;
                n_head  = '0;
                n_count = '0;
                n_rec   = (r_rec != RECOVERY_SAT) ? r_rec + 3'd1 : r_rec;
                n_powered = (n_rec <= r_max_rec);
                n_out   = '0;
                n_out.int_clear_mask = n_powered ? 4'hF : 4'h0;
            end
            MODE_SUBMIT: begin
                if (take) begin
                    n_state       = s2;
                    n_head        = h2;
                    n_count       = c2;
                    n_job_counter = seq;
                    n_out.accepted   = 1'b1;
                    n_out.job_number = seq;
                    n_out.bin_kick   = r_in.has_bin;
                    n_out.int_clear_mask = a1.clr | clr_m | a2.clr;
                    n_out.overflow_feed  = a1.feed | feed_m | a2.feed;
                    n_out.overflow_addr  = a2.feed ? a2.feed_addr
                                         : (feed_m ? addr_m : a1.feed_addr);
                    if (a2.kick) begin
                        n_out.render_kick       = 1'b1;
                        n_out.kick_render_start = e2.rl_start;
                        n_out.kick_render_end   = e2.rl_end;
                    end
                end
            end
            default: begin
            end
        endcase

        n_out.finished_number = n_state.finished_job;
        n_out.pipeline_idle   = !n_state.bin_busy && !n_state.render_busy
                                && n_count == '0
                                && n_state.finished_job == n_job_counter;
        n_out.slot_free       = !n_state.bin_busy && n_count < CW'(QUEUE_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_even <= '0;
            r_ovf_odd  <= '0;
            r_max_rec  <= MAX_REC_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OVF_EVEN: r_ovf_even <= i_cfg_data;
                CFG_OVF_ODD:  r_ovf_odd  <= i_cfg_data;
                CFG_MAX_REC:  r_max_rec  <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= '0;
            r_job_counter <= '0;
            r_head        <= '0;
            r_count       <= '0;
            r_powered     <= 1'b1;
            r_rec         <= '0;
        end else begin
            if (i_job.ready) begin
                r_in_valid <= i_job.valid;
            end
            if (adv) begin
                r_out_valid   <= 1'b1;
                r_state       <= n_state;
                r_job_counter <= n_job_counter;
                r_head        <= n_head;
                r_count       <= n_count;
                r_powered     <= n_powered;
                r_rec         <= n_rec;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.ready && i_job.valid) begin
            r_in <= i_job.payload;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ----- tb/gpu_bin_render_job_dispatcher_unit_tb.sv -----
`timescale 1ns / 1ps

module gpu_bin_render_job_dispatcher_unit_tb;
    import bjd_pkg::*;

    localparam int QDEPTH         = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_EVENTS   = 150;
    localparam int NUM_PHASES     = 5;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [3:0] F_NONE   = 4'd0;
    localparam logic [3:0] F_OOM    = 4'd1 << FLAG_OOM;
    localparam logic [3:0] F_FLUSH  = 4'd1 << FLAG_FLUSH;
    localparam logic [3:0] F_RENDER = 4'd1 << FLAG_RENDER;
    localparam logic [3:0] F_ALL    = 4'hF;

    // Receiver stall patterns.
    localparam int RX_ALWAYS  = 0;
    localparam int RX_COIN    = 1;
    localparam int RX_PATTERN = 2;
    localparam int RX_MOSTLY  = 3;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;

    bjd_stream_if #(.T(t_job_in))  job_ch ();
    bjd_stream_if #(.T(t_job_out)) res_ch ();

    gpu_bin_render_job_dispatcher_unit #(.QUEUE_DEPTH(QDEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Dispatcher state as the testbench tracks it.
    logic [31:0] cfg_ovf_even = '0;
    logic [31:0] cfg_ovf_odd  = '0;
    logic [2:0]  cfg_max_rec  = MAX_REC_DEFAULT;

    logic [31:0] m_job_counter  = '0;
    logic [31:0] m_bin_job      = '0;
    logic [31:0] m_flushed_job  = '0;
    logic [31:0] m_finished_job = '0;
    logic [31:0] m_render_job   = '0;
    bit          m_bin_busy     = 1'b0;
    bit          m_render_busy  = 1'b0;
    bit          m_bin_only     = 1'b0;
    bit          m_oom_waiting  = 1'b0;
    bit          m_oom_fed      = 1'b0;
    bit          m_powered      = 1'b1;
    t_qentry     m_queue [QDEPTH];
    int          m_q_head       = 0;
    int          m_q_count      = 0;
    logic [2:0]  m_rec_count    = '0;

    // Working values of one event.
    logic [3:0]  s_pend;
    logic [3:0]  s_clr;
    bit          s_feed;
    logic [31:0] s_feed_addr;
    bit          s_rkick;
    logic [31:0] s_rk_start;
    logic [31:0] s_rk_end;

    t_job_out dispatch_outcomes[$];
    t_job_out oldest_outcome;

    int n_events     = 0;
    int n_results    = 0;
    int n_errors     = 0;
    int n_jobs       = 0;
    int n_refused    = 0;
    int n_recoveries = 0;
    int n_bin_kicks  = 0;
    int n_rnd_kicks  = 0;
    int n_feeds      = 0;
    int burst_left   = 0;
    int stalled_cycles = 0;

    function automatic logic [31:0] overflow_supply(logic [31:0] job);
        return job[0] ? cfg_ovf_odd : cfg_ovf_even;
    endfunction

    function automatic void ack_flag(int bit_idx);
        s_pend[bit_idx] = 1'b0;
        s_clr[bit_idx]  = 1'b1;
    endfunction

    function automatic bit slot_open();
        return !m_bin_busy && (m_q_count < QDEPTH);
    endfunction

    function automatic void service_pass();
        logic [31:0] sup;
        t_qentry     head_e;
        if (s_pend[FLAG_OOM]) begin
            ack_flag(FLAG_OOM);
            m_oom_waiting = 1'b1;
        end
        if (s_pend[FLAG_SPILL]) ack_flag(FLAG_SPILL);

        // Only one refill per job, and only when the other supply exists.
        if (m_oom_waiting && !m_render_busy) begin
            sup = overflow_supply(m_bin_job + 32'd1);
            if (!m_oom_fed && sup != '0) begin
                s_feed      = 1'b1;
                s_feed_addr = sup;
                m_oom_fed   = 1'b1;
            end
            m_oom_waiting = 1'b0;
        end

        if (m_bin_busy && s_pend[FLAG_FLUSH]) begin
            ack_flag(FLAG_FLUSH);
            m_bin_busy    = 1'b0;
            m_flushed_job = m_bin_job;
            if (m_bin_only && m_finished_job < m_bin_job) m_finished_job = m_bin_job;
        end

        if (m_render_busy && s_pend[FLAG_RENDER]) begin
            ack_flag(FLAG_RENDER);
            m_render_busy  = 1'b0;
            m_finished_job = m_render_job;
        end

        if (m_q_count != 0 && !m_render_busy && m_queue[m_q_head].job <= m_flushed_job) begin
            head_e        = m_queue[m_q_head];
            m_render_job  = head_e.job;
            m_q_head      = (m_q_head + 1) % QDEPTH;
            m_q_count--;
            ack_flag(FLAG_RENDER);
            m_render_busy = 1'b1;
            s_rkick       = 1'b1;
            s_rk_start    = head_e.rl_start;
            s_rk_end      = head_e.rl_end;
        end
    endfunction

    function automatic t_job_out dispatch_event(t_job_in ev);
        t_job_out    r;
        logic [31:0] seq;
        logic [31:0] sup;
        int          tail;
        r = '0;
        s_pend[FLAG_OOM]    = ev.int_out_of_memory;
        s_pend[FLAG_SPILL]  = ev.int_spill;
        s_pend[FLAG_FLUSH]  = ev.int_bin_flushed;
        s_pend[FLAG_RENDER] = ev.int_render_done;
        s_clr       = '0;
        s_feed      = 1'b0;
        s_feed_addr = '0;
        s_rkick     = 1'b0;
        s_rk_start  = '0;
        s_rk_end    = '0;

        if (ev.mode == MODE_RECOVER) begin
            m_bin_busy     = 1'b0;
            m_render_busy  = 1'b0;
            m_q_head       = 0;
            m_q_count      = 0;
            m_flushed_job  = m_job_counter;
            m_finished_job = m_job_counter;
            m_powered      = 1'b0;
            if (m_rec_count < RECOVERY_SAT) m_rec_count++;
            if (m_rec_count <= cfg_max_rec) begin
                m_powered = 1'b1;
                s_clr     = F_ALL;
            end
        end else if (ev.mode == MODE_SUBMIT) begin
            service_pass();
            if (m_powered && slot_open()) begin
                seq           = m_job_counter + 32'd1;
                m_job_counter = seq;
                r.accepted    = 1'b1;
                r.job_number  = seq;
                if (ev.render_list_start != ev.render_list_end) begin
                    tail = (m_q_head + m_q_count) % QDEPTH;
                    m_queue[tail].rl_start = ev.render_list_start;
                    m_queue[tail].rl_end   = ev.render_list_end;
                    m_queue[tail].job      = seq;
                    m_q_count++;
                    m_bin_only = 1'b0;
                    if (!ev.has_bin) m_flushed_job = seq;
                end else begin
                    m_bin_only = 1'b1;
                    if (!ev.has_bin) m_finished_job = seq;
                end
                if (ev.has_bin) begin
                    sup = overflow_supply(seq);
                    if (sup != '0) begin
                        s_feed      = 1'b1;
                        s_feed_addr = sup;
                    end
                    ack_flag(FLAG_FLUSH);
                    m_bin_job     = seq;
                    m_bin_busy    = 1'b1;
                    m_oom_waiting = 1'b0;
                    m_oom_fed     = 1'b0;
                    r.bin_kick    = 1'b1;
                end
                service_pass();
            end
        end else begin
            service_pass();
        end

        r.render_kick       = s_rkick;
        r.kick_render_start = s_rk_start;
        r.kick_render_end   = s_rk_end;
        r.overflow_feed     = s_feed;
        r.overflow_addr     = s_feed_addr;
        r.finished_number   = m_finished_job;
        r.pipeline_idle     = !m_bin_busy && !m_render_busy && m_q_count == 0
                              && m_finished_job == m_job_counter;
        r.slot_free         = slot_open();
        r.int_clear_mask    = s_clr;
        return r;
    endfunction

    function automatic t_job_in mk_event(logic [1:0] mode, logic has_bin, logic [31:0] rs,
                                         logic [31:0] re, logic [3:0] flags);
        t_job_in ev;
        ev.mode              = mode;
        ev.has_bin           = has_bin;
        ev.render_list_start = rs;
        ev.render_list_end   = re;
        ev.int_out_of_memory = flags[FLAG_OOM];
        ev.int_spill         = flags[FLAG_SPILL];
        ev.int_bin_flushed   = flags[FLAG_FLUSH];
        ev.int_render_done   = flags[FLAG_RENDER];
        return ev;
    endfunction

    // Flags mostly follow what is actually running, with some spurious ones.
    function automatic t_job_in random_event();
        t_job_in ev;
        int      pick;
        pick = $urandom_range(0, 99);
        ev.has_bin           = ($urandom_range(0, 3) != 0);
        ev.render_list_start = $urandom();
        ev.render_list_end   = ($urandom_range(0, 4) == 0) ? ev.render_list_start : $urandom();
        ev.int_out_of_memory = m_bin_busy ? ($urandom_range(0, 5) == 0)
                                          : ($urandom_range(0, 19) == 0);
        ev.int_spill         = ($urandom_range(0, 4) == 0);
        ev.int_bin_flushed   = m_bin_busy ? ($urandom_range(0, 1) == 1)
                                          : ($urandom_range(0, 9) == 0);
        ev.int_render_done   = m_render_busy ? ($urandom_range(0, 1) == 1)
                                             : ($urandom_range(0, 9) == 0);
        if (pick < 2)       ev.mode = MODE_RECOVER;
        else if (pick < 5)  ev.mode = MODE_UNUSED;
        else if (pick < 42) ev.mode = MODE_SUBMIT;
        else                ev.mode = MODE_STATUS;
        return ev;
    endfunction

    task automatic show_result(string tag, t_job_out r);
        $display("  %s: acc=%0b job=%0h bk=%0b rk=%0b rs=%h re=%h feed=%0b fa=%h",
                 tag, r.accepted, r.job_number, r.bin_kick, r.render_kick,
                 r.kick_render_start, r.kick_render_end, r.overflow_feed, r.overflow_addr);
        $display("        fin=%0h idle=%0b slot=%0b clr=%h",
                 r.finished_number, r.pipeline_idle, r.slot_free, r.int_clear_mask);
    endtask

    // Sends one event in bursts with random gaps and predicts its outcome on acceptance.
    task automatic send_event(t_job_in ev);
        int       gap;
        t_job_out pred;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk) job_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        job_ch.valid   <= 1'b1;
        job_ch.payload <= ev;
        do @(posedge i_clk); while (!job_ch.ready);
        pred = dispatch_event(ev);
        dispatch_outcomes.push_back(pred);
        n_events++;
        if (ev.mode == MODE_SUBMIT) begin
            if (pred.accepted) n_jobs++;
            else n_refused++;
        end
        if (ev.mode == MODE_RECOVER) n_recoveries++;
        if (pred.bin_kick) n_bin_kicks++;
        if (pred.render_kick) n_rnd_kicks++;
        if (pred.overflow_feed) n_feeds++;
    endtask

    // Drops valid and waits until every predicted result has come back.
    task automatic settle();
        @(negedge i_clk) job_ch.valid <= 1'b0;
        while (dispatch_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk) cfg_we <= 1'b0;
        if (idx == CFG_OVF_EVEN) cfg_ovf_even = data;
        else if (idx == CFG_OVF_ODD) cfg_ovf_odd = data;
        else if (idx == CFG_MAX_REC) cfg_max_rec = data[2:0];
    endtask

    task automatic test_idle_polls();
        send_event(mk_event(MODE_STATUS, 1'b0, '0, '0, F_NONE));
        send_event(mk_event(MODE_STATUS, 1'b1, '1, '1, F_ALL));
        send_event(mk_event(MODE_UNUSED, 1'b0, '0, '0, F_NONE));
    endtask

    task automatic test_submit_flow();
        settle();
        write_reg(CFG_OVF_EVEN, 32'hFFFF_FFFF);
        write_reg(CFG_OVF_ODD, 32'h0000_0001);
        // Binned job with a render list, then a refused submission while binning.
        send_event(mk_event(MODE_SUBMIT, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, F_NONE));
        send_event(mk_event(MODE_SUBMIT, 1'b1, 32'h1234_5678, 32'h8765_4321, F_NONE));
        // The second out-of-memory in one job must not be refilled.
        send_event(mk_event(MODE_STATUS, 1'b0, '0, '0, F_OOM));
        send_event(mk_event(MODE_STATUS, 1'b0, '0, '0, F_OOM));
        send_event(mk_event(MODE_STATUS, 1'b0, '0, '0, F_FLUSH));
        send_event(mk_event(MODE_SUBMIT, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, F_NONE));
        send_event(mk_event(MODE_STATUS, 1'b0, '0, '0, F_RENDER));
        send_event(mk_event(MODE_STATUS, 1'b0, '0, '0, F_RENDER));
        // Bin-only job, then a job with neither list.
        send_event(mk_event(MODE_SUBMIT, 1'b1, 32'h0000_0005, 32'h0000_0005, F_NONE));
        send_event(mk_event(MODE_STATUS, 1'b0, '0, '0, F_FLUSH));
        send_event(mk_event(MODE_SUBMIT, 1'b0, 32'h0000_0000, 32'h0000_0000, F_NONE));
    endtask

    task automatic test_queue_full();
        // The first render starts at once; four more fill the queue, the last is refused.
        repeat (6) send_event(mk_event(MODE_SUBMIT, 1'b0, $urandom(), $urandom() | 32'h1, F_NONE));
        send_event(mk_event(MODE_STATUS, 1'b0, '0, '0, F_RENDER));
    endtask

    task automatic test_recovery();
        settle();
        write_reg(CFG_MAX_REC, 3'd0);
        send_event(mk_event(MODE_SUBMIT, 1'b1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, F_NONE));
        send_event(mk_event(MODE_RECOVER, 1'b0, '0, '0, F_ALL));
        send_event(mk_event(MODE_SUBMIT, 1'b1, 32'h0000_1000, 32'h0000_2000, F_NONE));
        settle();
        write_reg(CFG_MAX_REC, 3'd7);
        send_event(mk_event(MODE_RECOVER, 1'b1, '1, '0, F_NONE));
        send_event(mk_event(MODE_SUBMIT, 1'b1, 32'h0000_3000, 32'h0000_4000, F_NONE));
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            case (phase)
                0: begin
                    write_reg(CFG_OVF_EVEN, $urandom());
                    write_reg(CFG_OVF_ODD, $urandom());
                    write_reg(CFG_MAX_REC, 3'd7);
                end
                1: begin
                    write_reg(CFG_OVF_EVEN, 32'h0000_0000);
                    write_reg(CFG_OVF_ODD, 32'hFFFF_FFFF);
                    write_reg(CFG_MAX_REC, 3'd2);
                end
                2: begin
                    write_reg(CFG_OVF_EVEN, $urandom());
                    write_reg(CFG_OVF_ODD, 32'h0000_0000);
                    write_reg(CFG_MAX_REC, 3'd0);
                end
                3: begin
                    write_reg(CFG_OVF_EVEN, 32'hFFFF_FFFF);
                    write_reg(CFG_OVF_ODD, $urandom());
                    write_reg(CFG_MAX_REC, 3'd5);
                end
                default: begin
                    write_reg(CFG_OVF_EVEN, $urandom());
                    write_reg(CFG_OVF_ODD, $urandom());
                    write_reg(CFG_MAX_REC, 3'd7);
                end
            endcase
            repeat (PHASE_EVENTS) send_event(random_event());
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver picks a new stall pattern at random whenever the current one runs out.
    initial begin
        int stall_mode;
        int mode_left;
        int tick;
        res_ch.ready = 1'b0;
        stall_mode   = RX_ALWAYS;
        mode_left    = 0;
        tick         = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                stall_mode = $urandom_range(RX_ALWAYS, RX_MOSTLY);
                mode_left  = $urandom_range(32, 256);
            end
            mode_left--;
            tick++;
            case (stall_mode)
                RX_ALWAYS:  res_ch.ready <= 1'b1;
                RX_COIN:    res_ch.ready <= ($urandom_range(0, 1) == 1);
                RX_PATTERN: res_ch.ready <= ((tick % 11) < 7);
                default:    res_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            n_results++;
            if (dispatch_outcomes.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("ERROR: result %0d arrived with nothing predicted", n_results);
                    show_result("got", res_ch.payload);
                end
            end else begin
                oldest_outcome = dispatch_outcomes.pop_front();
                if (res_ch.payload !== oldest_outcome) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("ERROR: result %0d differs", n_results);
                        show_result("exp", oldest_outcome);
                        show_result("got", res_ch.payload);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (job_ch.valid && job_ch.ready) || (res_ch.valid && res_ch.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", stalled_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        job_ch.valid   = 1'b0;
        job_ch.payload = '0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_idle_polls();
        test_submit_flow();
        test_queue_full();
        test_recovery();
        test_random_traffic();

        @(negedge i_clk) job_ch.valid <= 1'b0;
        while (dispatch_outcomes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (dispatch_outcomes.size() != 0) begin
            n_errors += dispatch_outcomes.size();
            $display("ERROR: %0d predicted results never arrived", dispatch_outcomes.size());
        end

        $display("Ran %0d events: %0d jobs taken, %0d submissions refused, %0d recoveries.",
                 n_events, n_jobs, n_refused, n_recoveries);
        $display("Saw %0d bin kicks, %0d render kicks, %0d overflow feeds; %0d errors.",
                 n_bin_kicks, n_rnd_kicks, n_feeds, n_errors);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
